// ===== design/lz10wd_pkg.sv =====
// Shared constants for the LZ type-0x10 window decompressor.
package lz10wd_pkg;

	localparam int WINDOW_DEPTH_DEF = 4096;
	localparam int SIZE_W = 24;
	localparam int DIST_W = 12;
	localparam int LEN_W = 5;

	localparam logic [LEN_W-1:0] LEN_BASE = 5'd3;

	localparam logic [1:0] PH_FLAG = 2'd0;
	localparam logic [1:0] PH_TOKEN = 2'd1;
	localparam logic [1:0] PH_MATCH2 = 2'd2;

	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_BADDIST = 2'd2;
	localparam logic [1:0] ST_OVERRUN = 2'd3;

endpackage

// ===== design/lz10wd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lz10wd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = lz10wd_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/lz10_window_decompressor_top.sv =====
// Top level of the LZ type-0x10 window decompressor: parser, copy sequencer, output register.
// One compressed byte is taken per request, and the block then holds in_stall high until
// that byte's results are in the output register. A flag byte, the first byte of a match,
// a match that fails its distance or size check, or any byte after the stream has stopped
// gives one empty result; a literal gives one byte. Such requests pass through capture and
// decode. A match of 3 to 18 bytes adds a copy loop that moves one byte per cycle, while
// the output is not stalled, through the single read port of the history RAM, writing it
// back at the output position. The history RAM holds WINDOW_DEPTH bytes (a power of two,
// at least 4096) and needs no clearing: every read is checked against the byte count first.
module lz10_window_decompressor_top #(
	parameter int WINDOW_DEPTH = lz10wd_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lz10wd_pkg::SIZE_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          in_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          byte_valid,
	output logic                          run_last,
	output logic [1:0]                    status,
	output logic [lz10wd_pkg::SIZE_W-1:0] out_count
);

	localparam int ADDR_W = $clog2(WINDOW_DEPTH);
	localparam int SW = lz10wd_pkg::SIZE_W;
	localparam int LW = lz10wd_pkg::LEN_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DECODE = 2'd1;
	localparam logic [1:0] S_COPY = 2'd2;

	localparam logic [1:0] K_EMPTY = 2'd0;
	localparam logic [1:0] K_LIT = 2'd1;
	localparam logic [1:0] K_COPY = 2'd2;

	// control state
	logic [1:0]    state_q;
	logic [1:0]    status_q;
	logic [SW-1:0] wc_q;
	logic [SW-1:0] size_q;
	logic [7:0]    flags_q;
	logic [3:0]    tok_q;
	logic [1:0]    phase_q;
	logic [7:0]    mh_q;
	logic [LW-1:0] k_q;
	logic          out_valid_q;

	// payload
	logic [7:0]        byte_q;
	logic              last_q;
	logic [ADDR_W-1:0] rd_q;
	logic [LW-1:0]     num_q;
	logic              dzero_q;
	logic [7:0]        last_byte_q;
	logic [7:0]        out_byte_q;
	logic              byte_valid_q;
	logic              run_last_q;
	logic [1:0]        status_out_q;
	logic [SW-1:0]     count_q;

	// decode
	logic [lz10wd_pkg::DIST_W-1:0] mdist;
	logic [LW-1:0]                 num;
	logic [SW:0]                   match_end;
	logic                          full;
	logic                          dist_bad;
	logic                          overrun;
	logic                          match_hit;
	logic                          lit_hit;
	logic [3:0]                    tok_dec;
	logic [1:0]                    kind;
	logic [1:0]                    nst;
	logic [1:0]                    nphase;
	logic [7:0]                    nflags;
	logic [3:0]                    ntok;
	logic [7:0]                    nmh;
	logic [ADDR_W-1:0]             rd0;

	logic          out_free;
	logic          out_load;
	logic          dec_go;
	logic          copy_go;
	logic          k_last;
	logic [7:0]    copy_byte;
	logic [7:0]    ram_rdata;
	logic          ram_we;
	logic          ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]    ram_wdata;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign run_last = run_last_q;
	assign status = status_out_q;
	assign out_count = count_q;

	assign out_free = !out_valid_q || !out_stall;
	assign dec_go = (state_q == S_DECODE) && out_free;
	assign copy_go = (state_q == S_COPY) && out_free;
	assign out_load = (dec_go && (kind != K_COPY)) || copy_go;

	assign mdist = {mh_q[3:0], byte_q};
	assign num = LW'(mh_q[7:4]) + lz10wd_pkg::LEN_BASE;
	assign match_end = {1'b0, wc_q} + (SW+1)'(num);
	assign full = (wc_q >= size_q);
	assign dist_bad = ((SW'(mdist) + SW'(1)) > wc_q);
	assign overrun = (match_end > {1'b0, size_q});
	assign match_hit = (match_end == {1'b0, size_q});
	assign lit_hit = ((wc_q + SW'(1)) == size_q);
	assign tok_dec = tok_q - 4'd1;
	assign rd0 = wc_q[ADDR_W-1:0] - ADDR_W'(mdist) - ADDR_W'(1);

	always_comb begin
		kind = K_EMPTY;
		nst = status_q;
		nphase = phase_q;
		nflags = flags_q;
		ntok = tok_q;
		nmh = mh_q;
		if (status_q == lz10wd_pkg::ST_RUN) begin
			if (full) begin
				nst = lz10wd_pkg::ST_DONE;
			end else begin
				case (phase_q)
					lz10wd_pkg::PH_TOKEN: begin
						if (flags_q[7]) begin
							nmh = byte_q;
							nphase = lz10wd_pkg::PH_MATCH2;
						end else begin
							kind = K_LIT;
							nflags = {flags_q[6:0], 1'b0};
							ntok = tok_dec;
							nphase = (tok_dec == 4'd0) ? lz10wd_pkg::PH_FLAG
								: lz10wd_pkg::PH_TOKEN;
						end
					end
					lz10wd_pkg::PH_MATCH2: begin
						if (dist_bad) begin
							nst = lz10wd_pkg::ST_BADDIST;
						end else if (overrun) begin
							nst = lz10wd_pkg::ST_OVERRUN;
						end else begin
							kind = K_COPY;
							nflags = {flags_q[6:0], 1'b0};
							ntok = tok_dec;
							nphase = (tok_dec == 4'd0) ? lz10wd_pkg::PH_FLAG
								: lz10wd_pkg::PH_TOKEN;
						end
					end
					default: begin
						nflags = byte_q;
						ntok = 4'd8;
						nphase = lz10wd_pkg::PH_TOKEN;
					end
				endcase
				if (nst == lz10wd_pkg::ST_RUN) begin
					if ((kind == K_LIT && lit_hit) || (kind == K_COPY && match_hit)
						|| last_q) begin
						nst = lz10wd_pkg::ST_DONE;
					end
				end
			end
		end
	end

	assign k_last = (k_q == (num_q - LW'(1)));
	// a distance of one byte re-reads the byte just written: take it from the register
	assign copy_byte = (dzero_q && (k_q != '0)) ? last_byte_q : ram_rdata;

	assign ram_we = (dec_go && kind == K_LIT) || copy_go;
	assign ram_wdata = (state_q == S_COPY) ? copy_byte : byte_q;
	assign ram_re = (dec_go && kind == K_COPY) || (copy_go && !k_last);
	assign ram_raddr = (state_q == S_COPY) ? (rd_q + ADDR_W'(1)) : rd0;

	lz10wd_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk(clk),
		.we(ram_we),
		.waddr(wc_q[ADDR_W-1:0]),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= lz10wd_pkg::ST_RUN;
			wc_q <= '0;
			size_q <= '0;
			flags_q <= '0;
			tok_q <= '0;
			phase_q <= lz10wd_pkg::PH_FLAG;
			mh_q <= '0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				size_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (out_free) begin
						status_q <= nst;
						flags_q <= nflags;
						tok_q <= ntok;
						phase_q <= nphase;
						mh_q <= nmh;
						k_q <= '0;
						if (kind == K_COPY) begin
							state_q <= S_COPY;
						end else begin
							state_q <= S_IDLE;
							if (kind == K_LIT) begin
								wc_q <= wc_q + SW'(1);
							end
						end
					end
				end
				S_COPY: begin
					if (out_free) begin
						wc_q <= wc_q + SW'(1);
						k_q <= k_q + LW'(1);
						if (k_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			byte_q <= in_byte;
			last_q <= in_end;
		end
		if (dec_go) begin
			out_byte_q <= (kind == K_LIT) ? byte_q : 8'd0;
			byte_valid_q <= (kind == K_LIT);
			run_last_q <= 1'b1;
			status_out_q <= nst;
			count_q <= (kind == K_LIT) ? (wc_q + SW'(1)) : wc_q;
			rd_q <= rd0;
			num_q <= num;
			dzero_q <= (mdist == '0);
			if (kind == K_LIT) begin
				last_byte_q <= byte_q;
			end
		end
		if (copy_go) begin
			out_byte_q <= copy_byte;
			byte_valid_q <= 1'b1;
			run_last_q <= k_last;
			status_out_q <= status_q;
			count_q <= wc_q + SW'(1);
			rd_q <= rd_q + ADDR_W'(1);
			last_byte_q <= copy_byte;
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == lz10wd_pkg::ST_BADDIST || status_q == lz10wd_pkg::ST_OVERRUN)
		|=> status_q == $past(status_q))
		else $error("error status did not stick");

	a_no_byte_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && byte_valid_q) |->
		(status_out_q != lz10wd_pkg::ST_BADDIST && status_out_q != lz10wd_pkg::ST_OVERRUN))
		else $error("byte delivered with an error status");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !run_last_q) |-> byte_valid_q)
		else $error("non-final result without a byte");

	a_copy_writes: assert property (@(posedge clk) disable iff (!arst_n)
		copy_go |=> wc_q == $past(wc_q) + SW'(1))
		else $error("copy step did not advance the byte count");

endmodule

// ===== tb/tb_lz10_window_decompressor_top.sv =====
// Testbench for the LZ type-0x10 window decompressor: random stream driver, result checker.
module tb_lz10_window_decompressor_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYC = 500000;
	localparam int HOLD_CYC = 400;
	localparam int PHASE_ITEMS = 35;
	localparam int SIZE_W = lz10wd_pkg::SIZE_W;
	localparam int WDEPTH = lz10wd_pkg::WINDOW_DEPTH_DEF;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} lz_in_t;

	typedef struct packed {
		logic [7:0]        data;
		logic              vld;
		logic              last;
		logic [1:0]        st;
		logic [SIZE_W-1:0] cnt;
	} lz_result_t;

	typedef enum int {
		END_LIT,
		END_TRUNC,
		END_BADDIST,
		END_OVERRUN,
		END_EXACT,
		END_SHRINK
	} stream_end_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        in_byte = '0;
	logic              in_end = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        out_byte;
	logic              byte_valid;
	logic              run_last;
	logic [1:0]        status;
	logic [SIZE_W-1:0] out_count;

	lz10_window_decompressor_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_end     (in_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.status     (status),
		.out_count  (out_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// decoder shadow state
	logic [7:0]        win_mem [WDEPTH];
	logic [SIZE_W-1:0] wr_cnt = '0;
	logic [7:0]        flags = '0;
	logic [3:0]        tok_left = '0;
	logic [1:0]        phase = lz10wd_pkg::PH_FLAG;
	logic [7:0]        m_high = '0;
	logic [1:0]        st_now = lz10wd_pkg::ST_RUN;
	logic [SIZE_W-1:0] size_reg = '0;

	lz_in_t     compressed_q [$];
	lz_result_t decoded_q [$];

	int gen_cnt = 0;
	int n_items = 0;
	int gap_max = 6;
	int hold_req = 0;
	int err_cnt = 0;
	int cyc = 0;
	int n_in_acc = 0;
	int n_out_acc = 0;

	task automatic lz_decode_byte(input logic [7:0] b, input logic fin);
		logic [SIZE_W-1:0] start;
		logic [11:0]       back;
		logic [4:0]        num;
		logic [7:0]        run_q [$];
		logic [7:0]        c;
		lz_result_t        r;
		start = wr_cnt;
		if (st_now == lz10wd_pkg::ST_RUN) begin
			if (wr_cnt >= size_reg) begin
				st_now = lz10wd_pkg::ST_DONE;
			end else if (phase == lz10wd_pkg::PH_TOKEN) begin
				if (flags[7]) begin
					m_high = b;
					phase = lz10wd_pkg::PH_MATCH2;
				end else begin
					win_mem[int'(wr_cnt) % WDEPTH] = b;
					wr_cnt = wr_cnt + 1'b1;
					run_q.push_back(b);
					flags = flags << 1;
					tok_left = tok_left - 1'b1;
					phase = (tok_left == 0) ? lz10wd_pkg::PH_FLAG : lz10wd_pkg::PH_TOKEN;
				end
			end else if (phase == lz10wd_pkg::PH_MATCH2) begin
				back = {m_high[3:0], b};
				num = lz10wd_pkg::LEN_BASE + m_high[7:4];
				if (25'(back) + 25'd1 > 25'(wr_cnt)) begin
					st_now = lz10wd_pkg::ST_BADDIST;
				end else if (25'(wr_cnt) + 25'(num) > 25'(size_reg)) begin
					st_now = lz10wd_pkg::ST_OVERRUN;
				end else begin
					for (int k = 0; k < num; k++) begin
						c = win_mem[(int'(wr_cnt) - int'(back) - 1) % WDEPTH];
						win_mem[int'(wr_cnt) % WDEPTH] = c;
						wr_cnt = wr_cnt + 1'b1;
						run_q.push_back(c);
					end
					flags = flags << 1;
					tok_left = tok_left - 1'b1;
					phase = (tok_left == 0) ? lz10wd_pkg::PH_FLAG : lz10wd_pkg::PH_TOKEN;
				end
			end else begin
				flags = b;
				tok_left = 4'd8;
				phase = lz10wd_pkg::PH_TOKEN;
			end
			if (st_now == lz10wd_pkg::ST_RUN && wr_cnt >= size_reg)
				st_now = lz10wd_pkg::ST_DONE;
			if (st_now == lz10wd_pkg::ST_RUN && fin)
				st_now = lz10wd_pkg::ST_DONE;
		end
		if (run_q.size() == 0) begin
			r = {8'h00, 1'b0, 1'b1, st_now, wr_cnt};
			decoded_q.push_back(r);
		end else begin
			for (int k = 0; k < run_q.size(); k++) begin
				r = {run_q[k], 1'b1, k == run_q.size() - 1, st_now,
					start + SIZE_W'(k) + 1'b1};
				decoded_q.push_back(r);
			end
		end
	endtask

	// input driver
	lz_in_t cur;
	logic   drv_busy = 1'b0;
	int     in_gap = 0;
	int     n_in_seen = 0;

	always @(negedge clk) begin
		if (drv_busy && n_in_acc != n_in_seen) begin
			n_in_seen = n_in_acc;
			drv_busy = 1'b0;
			in_gap = $urandom_range(0, gap_max);
		end
		if (!drv_busy) begin
			if (in_gap > 0) begin
				in_gap--;
			end else if (compressed_q.size() != 0) begin
				cur = compressed_q.pop_front();
				in_byte <= cur.data;
				in_end <= cur.fin;
				drv_busy = 1'b1;
			end
		end
		in_valid <= drv_busy;
	end

	// output stall control, long hold on request
	int n_out_seen = 0;
	int out_wait = 0;
	int hold_seen = 0;
	int hold_left = 0;

	always @(negedge clk) begin
		if (n_out_acc != n_out_seen) begin
			n_out_seen = n_out_acc;
			out_wait = $urandom_range(0, gap_max);
		end
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYC;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (out_wait > 0) begin
			out_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor and checker
	lz_result_t got, want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				lz_decode_byte(in_byte, in_end);
				n_in_acc++;
			end
			if (out_valid && !out_stall) begin
				n_out_acc++;
				got = {out_byte, byte_valid, run_last, status, out_count};
				if (decoded_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result: byte %02h vld %0d last %0d st %0d cnt %0d",
							got.data, got.vld, got.last, got.st, got.cnt);
				end else begin
					want = decoded_q.pop_front();
					if (got.data !== want.data || got.vld !== want.vld ||
						got.last !== want.last || got.st !== want.st ||
						got.cnt !== want.cnt) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("mismatch: want %02h/%0d/%0d/%0d/%0d got %02h/%0d/%0d/%0d/%0d",
								want.data, want.vld, want.last, want.st, want.cnt,
								got.data, got.vld, got.last, got.st, got.cnt);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > LIMIT_CYC) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic push_item(input logic [7:0] b, input logic fin);
		compressed_q.push_back({b, fin});
		n_items++;
	endtask

	task automatic push_lit(input logic [7:0] b);
		push_item(b, 1'b0);
		gen_cnt++;
	endtask

	task automatic push_match(input logic [3:0] len_nib, input logic [11:0] back);
		push_item({len_nib, back[11:8]}, 1'b0);
		push_item(back[7:0], 1'b0);
		gen_cnt += 3 + len_nib;
	endtask

	// one flag byte and its eight tokens, matches always reach written history
	task automatic gen_group(input int lit_pct);
		logic [7:0]  flag;
		logic [3:0]  len_nib [8];
		logic [11:0] back [8];
		logic [7:0]  lit [8];
		int          cnt;
		int          lim;
		cnt = gen_cnt;
		for (int i = 7; i >= 0; i--) begin
			flag[i] = (cnt != 0) && ($urandom_range(1, 100) > lit_pct);
			if (flag[i]) begin
				len_nib[i] = 4'($urandom_range(0, 15));
				lim = (cnt < WDEPTH) ? cnt : WDEPTH;
				if ($urandom_range(0, 1))
					back[i] = 12'($urandom_range(0, lim - 1));
				else
					back[i] = 12'($urandom_range(0, ((lim < 8) ? lim : 8) - 1));
				cnt += 3 + len_nib[i];
			end else begin
				lit[i] = 8'($urandom);
				cnt++;
			end
		end
		push_item(flag, 1'b0);
		for (int i = 7; i >= 0; i--) begin
			if (flag[i])
				push_match(len_nib[i], back[i]);
			else
				push_lit(lit[i]);
		end
	endtask

	task automatic wait_drained();
		while (compressed_q.size() != 0 || drv_busy || decoded_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] v);
		wait_drained();
		@(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		size_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int          mark;
		int          pct;
		stream_end_t how;
		for (int i = 0; i < WDEPTH; i++)
			win_mem[i] = 8'h00;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_size({SIZE_W{1'b1}});

		// literals at the byte extremes, then matches incl. full overlap and oldest byte
		push_item(8'h00, 1'b0);
		push_lit(8'h00);
		push_lit(8'hFF);
		push_lit(8'hA5);
		push_lit(8'h5A);
		push_lit(8'h01);
		push_lit(8'h80);
		push_lit(8'h7F);
		push_lit(8'hFE);
		push_item(8'hFF, 1'b0);
		push_match(4'hF, 12'd0);
		push_match(4'h0, 12'd0);
		push_match(4'hF, 12'd7);
		push_match(4'h5, 12'd28);
		push_match(4'h1, 12'd54);
		push_match(4'hA, 12'd47);
		push_match(4'h3, 12'd16);
		push_match(4'hF, 12'd77);

		// size change mid-stream
		write_size(24'h010000);

		for (int ph = 0; ph < 4; ph++) begin
			gap_max = (ph == 2) ? 0 : 6;
			mark = n_items;
			while (n_items - mark < PHASE_ITEMS) begin
				case ($urandom_range(0, 2))
					0: pct = 10;
					1: pct = 50;
					default: pct = 90;
				endcase
				gen_group(pct);
			end
			if (ph == 1)
				hold_req++;
			case (ph)
				0: write_size(SIZE_W'($urandom_range(gen_cnt + 4000, 24'hFFFFFF)));
				1: write_size(SIZE_W'(gen_cnt + 4000));
				2: write_size(24'h800000);
				default: write_size({SIZE_W{1'b1}});
			endcase
		end
		gap_max = 6;

		how = stream_end_t'($urandom_range(0, 5));
		case (how)
			END_LIT: begin
				push_item(8'h00, 1'b0);
				push_item(8'($urandom), 1'b1);
			end
			END_TRUNC: begin
				push_item(8'hC0, 1'b0);
				push_item(8'($urandom), 1'b1);
			end
			END_BADDIST: begin
				push_item(8'h80, 1'b0);
				push_item({4'($urandom), 4'hF}, 1'b0);
				push_item(8'hFF, 1'($urandom));
			end
			END_OVERRUN: begin
				write_size(SIZE_W'(gen_cnt + 5));
				push_item(8'h80, 1'b0);
				push_match(4'hF, 12'd0);
			end
			END_EXACT: begin
				write_size(SIZE_W'(gen_cnt + 18));
				push_item(8'h80, 1'b0);
				push_match(4'hF, 12'd0);
			end
			default: begin
				write_size('0);
				push_item(8'($urandom), 1'b0);
			end
		endcase

		// stream has stopped; everything after gives empty results
		repeat (6) push_item(8'($urandom), 1'($urandom));
		write_size('0);
		repeat (6) push_item(8'($urandom), 1'($urandom));
		write_size({SIZE_W{1'b1}});
		repeat (6) push_item(8'($urandom), 1'($urandom));

		wait_drained();
		repeat (40) @(posedge clk);
		if (err_cnt == 0 && decoded_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
